### hw/rtl/rtf_pkg.sv
package rtf_pkg;

   // cordic
   localparam int MAX_STAGES        = 24;
   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ZW = 28;   // angle, Q.24 rad
   localparam int VW = 38;   // vectoring datapath
   localparam int CW = 34;   // rotation datapath, Q.30

   localparam logic signed [ZW-1:0] ANG_PI      = 28'sd52707179;
   localparam logic signed [ZW-1:0] ANG_HALF_PI = 28'sd26353589;
   localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;

   // offsets and root
   localparam int TW      = 28;
   localparam int SQ_BITS = 22;
   localparam int RW      = 45;

   // register map
   localparam int IDX_W = 3;
   localparam logic [IDX_W-1:0] REG_GAIN_X         = 3'd0;
   localparam logic [IDX_W-1:0] REG_GAIN_Y         = 3'd1;
   localparam logic [IDX_W-1:0] REG_GAIN_YAW       = 3'd2;
   localparam logic [IDX_W-1:0] REG_POS_DEADBAND   = 3'd3;
   localparam logic [IDX_W-1:0] REG_VEL_LIMIT      = 3'd4;
   localparam logic [IDX_W-1:0] REG_YAW_DEADBAND   = 3'd5;
   localparam logic [IDX_W-1:0] REG_YAW_RATE_LIMIT = 3'd6;

   localparam logic [15:0] RST_GAIN     = 16'd4096;
   localparam logic [24:0] RST_POS_DB   = 25'd98304;
   localparam logic [24:0] RST_VEL_LIM  = 25'd327680;
   localparam logic [13:0] RST_YAW_DB   = 14'd286;
   localparam logic [13:0] RST_YAW_LIM  = 14'd4289;

   function automatic logic signed [ZW-1:0] rtf_atan(input int idx);
      case (idx)
         0:  return 28'sd13176795;
         1:  return 28'sd7778716;
         2:  return 28'sd4110060;
         3:  return 28'sd2086331;
         4:  return 28'sd1047214;
         5:  return 28'sd524117;
         6:  return 28'sd262123;
         7:  return 28'sd131069;
         8:  return 28'sd65536;
         9:  return 28'sd32768;
         10: return 28'sd16384;
         11: return 28'sd8192;
         12: return 28'sd4096;
         13: return 28'sd2048;
         14: return 28'sd1024;
         15: return 28'sd512;
         16: return 28'sd256;
         17: return 28'sd128;
         18: return 28'sd64;
         19: return 28'sd32;
         20: return 28'sd16;
         21: return 28'sd8;
         22: return 28'sd4;
         23: return 28'sd2;
         default: return '0;
      endcase
   endfunction

endpackage

### hw/rtl/rtf_delay.sv
module rtf_delay #(
   parameter int W = 1,
   parameter int D = 1
) (
   input  logic         clock,
   input  logic [W-1:0] in_data,
   output logic [W-1:0] out_data
);
   logic [W-1:0] pipe_ff [0:D-1];

   always_ff @(posedge clock) begin
      pipe_ff[0] <= in_data;
      for (int i = 1; i < D; i++) begin
         pipe_ff[i] <= pipe_ff[i-1];
      end
   end

   assign out_data = pipe_ff[D-1];
endmodule

### hw/rtl/rtf_vec_cell.sv
module rtf_vec_cell #(
   parameter int W   = rtf_pkg::VW,
   parameter int IDX = 0
) (
   input  logic                        clock,
   input  logic signed [W-1:0]         in_x,
   input  logic signed [W-1:0]         in_y,
   input  logic signed [rtf_pkg::ZW-1:0] in_z,
   output logic signed [W-1:0]         out_x,
   output logic signed [W-1:0]         out_y,
   output logic signed [rtf_pkg::ZW-1:0] out_z
);
   import rtf_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = rtf_atan(IDX);

   logic signed [W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;

   // drive y toward zero
   always_comb begin
      if (!in_y[W-1]) begin
         x_in = in_x + (in_y >>> IDX);
         y_in = in_y - (in_x >>> IDX);
         z_in = in_z + ATAN;
      end else begin
         x_in = in_x - (in_y >>> IDX);
         y_in = in_y + (in_x >>> IDX);
         z_in = in_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;
endmodule

### hw/rtl/rtf_rot_cell.sv
module rtf_rot_cell #(
   parameter int IDX = 0
) (
   input  logic                          clock,
   input  logic signed [rtf_pkg::CW-1:0] in_x,
   input  logic signed [rtf_pkg::CW-1:0] in_y,
   input  logic signed [rtf_pkg::ZW-1:0] in_z,
   output logic signed [rtf_pkg::CW-1:0] out_x,
   output logic signed [rtf_pkg::CW-1:0] out_y,
   output logic signed [rtf_pkg::ZW-1:0] out_z
);
   import rtf_pkg::*;

   localparam logic signed [ZW-1:0] ATAN = rtf_atan(IDX);

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;

   // drive residual angle toward zero
   always_comb begin
      if (!in_z[ZW-1]) begin
         x_in = in_x - (in_y >>> IDX);
         y_in = in_y + (in_x >>> IDX);
         z_in = in_z - ATAN;
      end else begin
         x_in = in_x + (in_y >>> IDX);
         y_in = in_y - (in_x >>> IDX);
         z_in = in_z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_z = z_ff;
endmodule

### hw/rtl/rtf_sqrt_cell.sv
module rtf_sqrt_cell #(
   parameter int P = 0
) (
   input  logic                               clock,
   input  logic [rtf_pkg::RW-1:0]             in_rem,
   input  logic [rtf_pkg::SQ_BITS-1:0]        in_root,
   output logic [rtf_pkg::RW-1:0]             out_rem,
   output logic [rtf_pkg::SQ_BITS-1:0]        out_root
);
   import rtf_pkg::*;

   logic [RW-1:0]      trial;
   logic [RW-1:0]      rem_ff, rem_in;
   logic [SQ_BITS-1:0] root_ff, root_in;

   // (q + 2^P)^2 - q^2 = q*2^(P+1) + 2^(2P)
   always_comb begin
      trial = (RW'(in_root) << (P + 1)) + (RW'(1) << (2 * P));
      if (in_rem >= trial) begin
         rem_in  = in_rem - trial;
         root_in = in_root | (SQ_BITS'(1) << P);
      end else begin
         rem_in  = in_rem;
         root_in = in_root;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign out_rem  = rem_ff;
   assign out_root = root_ff;
endmodule

### hw/rtl/radar_target_follow_guidance.sv
// Radar target following guidance, fully pipelined.
// The path from start to rsp_valid runs through two CORDIC cell chains of NS = min(CORDIC_STAGES, 24)
// cells each and a 22-cell root chain.
// Throughput: one beat per cycle; busy is never raised.
// Reset (synchronous, active high) clears the valid line and restores the registers.
// The receiver cannot stall: each rsp_valid strobe lasts exactly one cycle.
module radar_target_follow_guidance #(
   parameter int CORDIC_STAGES = rtf_pkg::CORDIC_STAGES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic signed [15:0]            req_quat_w,
   input  logic signed [15:0]            req_quat_x,
   input  logic signed [15:0]            req_quat_y,
   input  logic signed [15:0]            req_quat_z,
   input  logic signed [31:0]            req_drone_x,
   input  logic signed [31:0]            req_drone_y,
   input  logic signed [25:0]            req_radar_x,
   input  logic signed [25:0]            req_radar_y,
   // response
   output logic                          rsp_valid,
   output logic signed [25:0]            rsp_vel_x,
   output logic signed [25:0]            rsp_vel_y,
   output logic signed [14:0]            rsp_yaw_rate,
   output logic signed [31:0]            rsp_target_local_x,
   output logic signed [31:0]            rsp_target_local_y,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rtf_pkg::IDX_W-1:0]     csr_index,
   input  logic [24:0]                   csr_wdata
);
   import rtf_pkg::*;

   localparam int NS  = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
   localparam int LAT = 31 + 2 * NS;

   // ---------------------------------------------------------------- registers
   logic [15:0] gain_x_ff, gain_y_ff, gain_yaw_ff;
   logic [24:0] band_ff, vlim_ff;
   logic [13:0] ydb_ff, ylim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_x_ff   <= RST_GAIN;
         gain_y_ff   <= RST_GAIN;
         gain_yaw_ff <= RST_GAIN;
         band_ff     <= RST_POS_DB;
         vlim_ff     <= RST_VEL_LIM;
         ydb_ff      <= RST_YAW_DB;
         ylim_ff     <= RST_YAW_LIM;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_GAIN_X:         gain_x_ff   <= csr_wdata[15:0];
            REG_GAIN_Y:         gain_y_ff   <= csr_wdata[15:0];
            REG_GAIN_YAW:       gain_yaw_ff <= csr_wdata[15:0];
            REG_POS_DEADBAND:   band_ff     <= csr_wdata;
            REG_VEL_LIMIT:      vlim_ff     <= csr_wdata;
            REG_YAW_DEADBAND:   ydb_ff      <= csr_wdata[13:0];
            REG_YAW_RATE_LIMIT: ylim_ff     <= csr_wdata[13:0];
            default: ;  // beyond the map: dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- valid line
   logic       accept;
   logic [LAT:1] vld_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-1:1], accept};
      end
   end

   assign rsp_valid = vld_ff[LAT];

   // ---------------------------------------------------------------- stage 1
   // quaternion products; radar axes swapped into body frame
   logic signed [31:0] p_wz_ff, p_xy_ff, p_yy_ff, p_zz_ff;
   logic signed [25:0] bx1_ff, by1_ff;
   logic signed [31:0] dx1_ff, dy1_ff;

   always_ff @(posedge clock) begin
      p_wz_ff <= 32'(req_quat_w) * 32'(req_quat_z);
      p_xy_ff <= 32'(req_quat_x) * 32'(req_quat_y);
      p_yy_ff <= 32'(req_quat_y) * 32'(req_quat_y);
      p_zz_ff <= 32'(req_quat_z) * 32'(req_quat_z);
      bx1_ff  <= req_radar_y;
      by1_ff  <= req_radar_x;
      dx1_ff  <= req_drone_x;
      dy1_ff  <= req_drone_y;
   end

   // ---------------------------------------------------------------- stage 2
   // yaw terms: sin = 2(wz+xy), cos = 1 - 2(yy+zz), both Q.28
   logic signed [33:0] siny_in, cosy_in, siny2_ff, cosy2_ff;
   logic signed [25:0] bx2_ff, by2_ff;

   always_comb begin
      siny_in = (34'(p_wz_ff) + 34'(p_xy_ff)) <<< 1;
      cosy_in = (34'sd1 <<< 28) - ((34'(p_yy_ff) + 34'(p_zz_ff)) <<< 1);
   end

   always_ff @(posedge clock) begin
      siny2_ff <= siny_in;
      cosy2_ff <= cosy_in;
      bx2_ff   <= bx1_ff;
      by2_ff   <= by1_ff;
   end

   // ---------------------------------------------------------------- stage 3
   // fold both vectors into the right half-plane before the chains
   logic signed [VW-1:0] yx_in, yy_in, yv_x_ff, yv_y_ff;
   logic signed [VW-1:0] bxe, bye, bx_in, by_in, bv_x_ff, bv_y_ff;
   logic signed [ZW-1:0] ybase_in, bval_in;
   logic                 yzero_in, bspec_in;
   logic [ZW:0]          yflag_ff, bflag_ff, yflag_d, bflag_d;

   always_comb begin
      yzero_in = (cosy2_ff == '0) && (siny2_ff == '0);
      if (cosy2_ff[33]) begin
         yx_in    = -VW'(cosy2_ff);
         yy_in    = -VW'(siny2_ff);
         ybase_in = siny2_ff[33] ? -ANG_PI : ANG_PI;
      end else begin
         yx_in    = VW'(cosy2_ff);
         yy_in    = VW'(siny2_ff);
         ybase_in = '0;
      end

      bxe = VW'(bx2_ff) <<< 8;
      bye = VW'(by2_ff) <<< 8;
      bspec_in = (bx2_ff == '0);
      if (by2_ff[25]) begin
         bval_in = -ANG_HALF_PI;
      end else if (by2_ff != '0) begin
         bval_in = ANG_HALF_PI;
      end else begin
         bval_in = '0;
      end
      if (bx2_ff[25]) begin
         bx_in = -bxe;
         by_in = -bye;
      end else begin
         bx_in = bxe;
         by_in = bye;
      end
   end

   always_ff @(posedge clock) begin
      yv_x_ff  <= yx_in;
      yv_y_ff  <= yy_in;
      bv_x_ff  <= bx_in;
      bv_y_ff  <= by_in;
      yflag_ff <= {yzero_in, ybase_in};
      bflag_ff <= {bspec_in, bval_in};
   end

   rtf_delay #(.W(ZW + 1), .D(NS)) u_yflag_dly (
      .clock(clock), .in_data(yflag_ff), .out_data(yflag_d));
   rtf_delay #(.W(ZW + 1), .D(NS)) u_bflag_dly (
      .clock(clock), .in_data(bflag_ff), .out_data(bflag_d));

   // vectoring chains: yaw and bearing side by side
   logic signed [VW-1:0] ych_x [0:NS];
   logic signed [VW-1:0] ych_y [0:NS];
   logic signed [ZW-1:0] ych_z [0:NS];
   logic signed [VW-1:0] bch_x [0:NS];
   logic signed [VW-1:0] bch_y [0:NS];
   logic signed [ZW-1:0] bch_z [0:NS];

   assign ych_x[0] = yv_x_ff;
   assign ych_y[0] = yv_y_ff;
   assign ych_z[0] = '0;
   assign bch_x[0] = bv_x_ff;
   assign bch_y[0] = bv_y_ff;
   assign bch_z[0] = '0;

   for (genvar k = 0; k < NS; k++) begin : g_vec
      rtf_vec_cell #(.W(VW), .IDX(k)) u_yaw (
         .clock(clock),
         .in_x(ych_x[k]), .in_y(ych_y[k]), .in_z(ych_z[k]),
         .out_x(ych_x[k+1]), .out_y(ych_y[k+1]), .out_z(ych_z[k+1]));
      rtf_vec_cell #(.W(VW), .IDX(k)) u_brg (
         .clock(clock),
         .in_x(bch_x[k]), .in_y(bch_y[k]), .in_z(bch_z[k]),
         .out_x(bch_x[k+1]), .out_y(bch_y[k+1]), .out_z(bch_z[k+1]));
   end

   // ---------------------------------------------------------------- stage 4
   // yaw clamp to +/-pi and fold into +/-pi/2; bearing rounded to Q2.13
   logic signed [ZW-1:0] yz_sum, yz_clamp, rz_in, rz_ff, bz_clamp, bz_sel, bz_rnd;
   logic                 rneg_in, rneg_ff, rneg_d;
   logic signed [14:0]   b13_in, b13_ff;

   always_comb begin
      yz_sum = ych_z[NS] + yflag_d[ZW-1:0];
      if (yflag_d[ZW]) begin
         yz_clamp = '0;
      end else if (yz_sum > ANG_PI) begin
         yz_clamp = ANG_PI;
      end else if (yz_sum < -ANG_PI) begin
         yz_clamp = -ANG_PI;
      end else begin
         yz_clamp = yz_sum;
      end
      if (yz_clamp > ANG_HALF_PI) begin
         rz_in   = yz_clamp - ANG_PI;
         rneg_in = 1'b1;
      end else if (yz_clamp < -ANG_HALF_PI) begin
         rz_in   = yz_clamp + ANG_PI;
         rneg_in = 1'b1;
      end else begin
         rz_in   = yz_clamp;
         rneg_in = 1'b0;
      end

      if (bch_z[NS] > ANG_PI) begin
         bz_clamp = ANG_PI;
      end else if (bch_z[NS] < -ANG_PI) begin
         bz_clamp = -ANG_PI;
      end else begin
         bz_clamp = bch_z[NS];
      end
      bz_sel = bflag_d[ZW] ? bflag_d[ZW-1:0] : bz_clamp;
      bz_rnd = (bz_sel + 28'sd1024) >>> 11;
      b13_in = 15'(bz_rnd);
   end

   always_ff @(posedge clock) begin
      rz_ff   <= rz_in;
      rneg_ff <= rneg_in;
      b13_ff  <= b13_in;
   end

   rtf_delay #(.W(1), .D(NS)) u_rneg_dly (
      .clock(clock), .in_data(rneg_ff), .out_data(rneg_d));

   // rotation chain: cos/sin of the folded yaw, Q.30
   logic signed [CW-1:0] rch_x [0:NS];
   logic signed [CW-1:0] rch_y [0:NS];
   logic signed [ZW-1:0] rch_z [0:NS];

   assign rch_x[0] = CORDIC_K;
   assign rch_y[0] = '0;
   assign rch_z[0] = rz_ff;

   for (genvar k = 0; k < NS; k++) begin : g_rot
      rtf_rot_cell #(.IDX(k)) u_rot (
         .clock(clock),
         .in_x(rch_x[k]), .in_y(rch_y[k]), .in_z(rch_z[k]),
         .out_x(rch_x[k+1]), .out_y(rch_y[k+1]), .out_z(rch_z[k+1]));
   end

   // ---------------------------------------------------------------- yaw rate
   logic signed [31:0] rprod_ff, rrnd, ylim_w;
   logic signed [14:0] b13r_ff, rate_in, rate_ff;
   logic signed [15:0] b13e, ydb_s;

   always_ff @(posedge clock) begin
      rprod_ff <= 32'(b13_ff) * 32'($signed({1'b0, gain_yaw_ff}));
      b13r_ff  <= b13_ff;
   end

   always_comb begin
      rrnd   = (rprod_ff + 32'sd2048) >>> 12;
      ylim_w = {18'b0, ylim_ff};
      b13e   = 16'(b13r_ff);
      ydb_s  = {2'b0, ydb_ff};
      if ((b13e < ydb_s) && (b13e > -ydb_s)) begin
         rate_in = '0;          // inside the bearing band
      end else if (rrnd > ylim_w) begin
         rate_in = 15'(ylim_w);
      end else if (rrnd < -ylim_w) begin
         rate_in = 15'(-ylim_w);
      end else begin
         rate_in = 15'(rrnd);
      end
   end

   always_ff @(posedge clock) begin
      rate_ff <= rate_in;
   end

   rtf_delay #(.W(15), .D(25 + NS)) u_rate_dly (
      .clock(clock), .in_data(rate_ff), .out_data(rsp_yaw_rate));

   // ---------------------------------------------------------------- rotate offsets
   logic [51:0] bpair_d;
   logic [63:0] dpair_d;
   logic signed [25:0] bx_d, by_d;
   logic signed [26:0] bxn, byn;
   logic signed [60:0] m_xc_ff, m_ys_ff, m_xs_ff, m_yc_ff;
   logic signed [61:0] t_x, t_y;
   logic signed [TW-1:0] tx_ff [0:1];

   rtf_delay #(.W(52), .D(3 + 2 * NS)) u_body_dly (
      .clock(clock), .in_data({bx1_ff, by1_ff}), .out_data(bpair_d));
   rtf_delay #(.W(64), .D(5 + 2 * NS)) u_drone_dly (
      .clock(clock), .in_data({dx1_ff, dy1_ff}), .out_data(dpair_d));

   // folded yaw: negate the body offsets instead of cos/sin
   always_comb begin
      bx_d = bpair_d[51:26];
      by_d = bpair_d[25:0];
      bxn  = rneg_d ? -27'(bx_d) : 27'(bx_d);
      byn  = rneg_d ? -27'(by_d) : 27'(by_d);
   end

   always_ff @(posedge clock) begin
      m_xc_ff <= 61'(bxn) * 61'(rch_x[NS]);
      m_ys_ff <= 61'(byn) * 61'(rch_y[NS]);
      m_xs_ff <= 61'(bxn) * 61'(rch_y[NS]);
      m_yc_ff <= 61'(byn) * 61'(rch_x[NS]);
   end

   always_comb begin
      t_x = (62'(m_xc_ff) - 62'(m_ys_ff) + (62'sd1 <<< 29)) >>> 30;
      t_y = (62'(m_xs_ff) + 62'(m_yc_ff) + (62'sd1 <<< 29)) >>> 30;
   end

   always_ff @(posedge clock) begin
      tx_ff[0] <= TW'(t_x);
      tx_ff[1] <= TW'(t_y);
   end

   // ---------------------------------------------------------------- deadband, target
   logic signed [31:0] drone_d [0:1];
   logic [TW-1:0]      mag [0:1];
   logic [TW-1:0]      diff [0:1];
   logic               over [0:1];
   logic signed [32:0] tsum [0:1];
   logic signed [31:0] tgt_in [0:1];
   logic signed [31:0] tgt_ff [0:1];
   logic [RW-1:0]      sq_rem_ff [0:1];
   logic [1:0]         aflag_ff [0:1];
   logic [1:0]         aflag_d [0:1];
   logic signed [31:0] tgt_d [0:1];

   assign drone_d[0] = dpair_d[63:32];
   assign drone_d[1] = dpair_d[31:0];

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         mag[a]  = tx_ff[a][TW-1] ? TW'(-tx_ff[a]) : TW'(tx_ff[a]);
         over[a] = mag[a] > TW'(band_ff);
         diff[a] = mag[a] - TW'(band_ff);
         tsum[a] = 33'(drone_d[a]) + 33'(tx_ff[a]);
         if (tsum[a] > 33'sd2147483647) begin
            tgt_in[a] = 32'sh7fffffff;
         end else if (tsum[a] < -33'sd2147483648) begin
            tgt_in[a] = 32'sh80000000;
         end else begin
            tgt_in[a] = 32'(tsum[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         sq_rem_ff[a] <= over[a] ? (RW'(diff[a]) << 16) : '0;
         aflag_ff[a]  <= {over[a], tx_ff[a][TW-1]};
         tgt_ff[a]    <= tgt_in[a];
      end
   end

   // ---------------------------------------------------------------- root chains
   logic [RW-1:0]      sq_rem  [0:1][0:SQ_BITS];
   logic [SQ_BITS-1:0] sq_root [0:1][0:SQ_BITS];

   for (genvar a = 0; a < 2; a++) begin : g_axis
      assign sq_rem[a][0]  = sq_rem_ff[a];
      assign sq_root[a][0] = '0;

      for (genvar k = 0; k < SQ_BITS; k++) begin : g_sqrt
         rtf_sqrt_cell #(.P(SQ_BITS - 1 - k)) u_sqrt (
            .clock(clock),
            .in_rem(sq_rem[a][k]), .in_root(sq_root[a][k]),
            .out_rem(sq_rem[a][k+1]), .out_root(sq_root[a][k+1]));
      end

      rtf_delay #(.W(2), .D(23)) u_aflag_dly (
         .clock(clock), .in_data(aflag_ff[a]), .out_data(aflag_d[a]));
      rtf_delay #(.W(32), .D(24)) u_tgt_dly (
         .clock(clock), .in_data(tgt_ff[a]), .out_data(tgt_d[a]));
   end

   assign rsp_target_local_x = tgt_d[0];
   assign rsp_target_local_y = tgt_d[1];

   // ---------------------------------------------------------------- gain, clamp
   logic [15:0]        gain_ax [0:1];
   logic [38:0]        g_ff [0:1];
   logic [26:0]        vmag [0:1];
   logic signed [25:0] vel_in [0:1];
   logic signed [25:0] vel_ff [0:1];

   assign gain_ax[0] = gain_x_ff;
   assign gain_ax[1] = gain_y_ff;

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         g_ff[a] <= 39'(sq_root[a][SQ_BITS]) * 39'(gain_ax[a]) + 39'd2048;
      end
   end

   always_comb begin
      for (int a = 0; a < 2; a++) begin
         vmag[a] = g_ff[a][38:12];
         if (vmag[a] > 27'(vlim_ff)) begin
            vmag[a] = 27'(vlim_ff);
         end
         if (!aflag_d[a][1]) begin
            vel_in[a] = '0;     // on or inside the band
         end else if (aflag_d[a][0]) begin
            vel_in[a] = -26'(vmag[a]);
         end else begin
            vel_in[a] = 26'(vmag[a]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         vel_ff[a] <= vel_in[a];
      end
   end

   assign rsp_vel_x = vel_ff[0];
   assign rsp_vel_y = vel_ff[1];

endmodule
